// File: design/tpitf_pkg.sv
// Package for the tiled palette icon texel fetch block.
// Holds the command codes, fixed sizes, color masks and the color conversion.
// No dependencies.
`timescale 1ns / 1ps

package tpitf_pkg;

    // Command codes carried by one transaction.
    typedef enum logic [1:0] {
        CMD_PAL_WR  = 2'd0,
        CMD_ICON_WR = 2'd1,
        CMD_READ    = 2'd2
    } t_cmd;

    localparam int PALETTE_SIZE = 16;
    localparam int TEX_DIM      = 64;

    localparam int CMD_W   = 2;
    localparam int PIDX_W  = 4;
    localparam int COLOR_W = 16;
    localparam int IADDR_W = 9;
    localparam int IBYTE_W = 8;
    localparam int TEX_W   = 6;

    localparam logic [15:0] G_MASK      = 16'h07C0;
    localparam logic [15:0] B_MASK      = 16'h003E;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;

    typedef logic [15:0] t_color;

    // BGR555 (xBBBBBGGGGGRRRRR) to RGB5A1 (RRRRRGGGGGBBBBBA) with alpha set.
    function automatic t_color convert_color(input t_color c);
        t_color r;
        t_color g;
        t_color b;
        r = {c[4:0], 11'b0};
        g = (c << 1) & G_MASK;
        b = (c >> 9) & B_MASK;
        return r | g | b | 16'h0001;
    endfunction

endpackage

// File: design/tiled_palette_icon_texel_fetch.sv
// Top level of the tiled palette icon texel fetch block.
// Holds the palette registers, the tiled icon memory and the two-stage read path.
// Depends on tpitf_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       i_cmd, i_palette_index, i_color_bgr555,
//                                                 i_icon_address, i_icon_byte, i_tex_x,
//                                                 i_tex_y
// texel     out        o_valid, one cycle strobe  o_texel_rgb5a1
//
// One transaction is accepted every cycle; busy stays low.
// A texel read shows its result after the registered icon memory read and then the
// palette lookup into the result register.
// Writes take effect at the accepting edge and return no result.
// Reset is synchronous and clears the palette and the pipeline valid flags;
// the icon memory is not cleared. The receiver cannot stall the result strobe.
module tiled_palette_icon_texel_fetch #(
    parameter int ICON_DIM = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tpitf_pkg::CMD_W-1:0]      i_cmd,
    input  logic [tpitf_pkg::PIDX_W-1:0]     i_palette_index,
    input  logic [tpitf_pkg::COLOR_W-1:0]    i_color_bgr555,
    input  logic [tpitf_pkg::IADDR_W-1:0]    i_icon_address,
    input  logic [tpitf_pkg::IBYTE_W-1:0]    i_icon_byte,
    input  logic [tpitf_pkg::TEX_W-1:0]      i_tex_x,
    input  logic [tpitf_pkg::TEX_W-1:0]      i_tex_y,
    output logic                             o_valid,
    output logic [15:0]                      o_texel_rgb5a1
);

    localparam int ICON_BYTES    = ICON_DIM * ICON_DIM / 2;
    localparam int TILES_PER_ROW = ICON_DIM / 8;
    localparam int IW            = $clog2(ICON_BYTES);
    localparam int AC_W          = $clog2(ICON_DIM * ICON_DIM * 4);
    localparam int WA_W          = ((IW > tpitf_pkg::IADDR_W) ? IW : tpitf_pkg::IADDR_W) + 1;

    // Storage.
    tpitf_pkg::t_color  r_pal [tpitf_pkg::PALETTE_SIZE];
    logic [7:0]         r_icon [ICON_BYTES];

    // Pipeline registers.
    logic               r_s1_valid;
    logic               r_s1_hit;
    logic               r_s1_hi;
    logic [7:0]         r_s1_byte;
    logic               r_out_valid;
    tpitf_pkg::t_color  r_out_texel;

    logic               accept;
    logic               pal_we;
    logic               icon_we;
    logic               rd_en;
    logic [WA_W-1:0]    wr_addr;
    logic               wr_in_range;
    logic               in_icon;
    logic [AC_W-1:0]    tile_idx;
    logic [AC_W-1:0]    rd_addr;
    logic               rd_hit;
    logic [3:0]         pix_idx;
    tpitf_pkg::t_color  n_out_texel;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the command of an accepted transaction.
    always_comb begin
        pal_we  = 1'b0;
        icon_we = 1'b0;
        rd_en   = 1'b0;
        case (tpitf_pkg::t_cmd'(i_cmd))
            tpitf_pkg::CMD_PAL_WR:  pal_we  = accept && (i_palette_index != '0);
            tpitf_pkg::CMD_ICON_WR: icon_we = accept;
            tpitf_pkg::CMD_READ:    rd_en   = accept;
            default: ;
        endcase
    end

    // Icon write address, widened so the range check covers any icon size.
    assign wr_addr     = WA_W'(i_icon_address);
    assign wr_in_range = (wr_addr < WA_W'(ICON_BYTES));

    // Tiled byte address of texel (x,y): 8x8 tiles, 4 bytes per tile row.
    assign in_icon  = ({2'b0, i_tex_x} < 8'(tpitf_pkg::TEX_DIM))
                   && ({2'b0, i_tex_y} < 8'(tpitf_pkg::TEX_DIM))
                   && ({2'b0, i_tex_x} < 8'(ICON_DIM))
                   && ({2'b0, i_tex_y} < 8'(ICON_DIM));
    assign tile_idx = AC_W'(i_tex_y >> 3) * AC_W'(TILES_PER_ROW) + AC_W'(i_tex_x >> 3);
    assign rd_addr  = (tile_idx << 5) + (AC_W'(i_tex_y[2:0]) << 2) + AC_W'(i_tex_x[2:1]);
    assign rd_hit   = in_icon && (rd_addr < AC_W'(ICON_BYTES));

    // Palette registers; entry zero is never written and stays transparent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tpitf_pkg::PALETTE_SIZE; i++) begin
                r_pal[i] <= '0;
            end
        end else if (pal_we) begin
            r_pal[i_palette_index] <= tpitf_pkg::convert_color(i_color_bgr555);
        end
    end

    // Icon memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (icon_we && wr_in_range) begin
            r_icon[wr_addr[IW-1:0]] <= i_icon_byte;
        end
        r_s1_byte <= r_icon[rd_addr[IW-1:0]];
    end

    // Stage one control: read in flight, address hit, nibble select.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= rd_en;
        end
        r_s1_hit <= rd_hit;
        r_s1_hi  <= i_tex_x[0];
    end

    // Palette lookup of the selected pixel.
    assign pix_idx     = (r_s1_hi ? r_s1_byte[7:4] : r_s1_byte[3:0]) & tpitf_pkg::NIBBLE_MASK;
    assign n_out_texel = r_s1_hit ? r_pal[pix_idx] : '0;

    // Result register and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s1_valid;
        end
        r_out_texel <= n_out_texel;
    end

    assign o_valid        = r_out_valid;
    assign o_texel_rgb5a1 = r_out_texel;

endmodule

// File: design/tpitf_checker.sv
// Port-level checker for the tiled palette icon texel fetch block.
// Watches only the top level's ports and is bound to it at the end of this file.
// Depends on tpitf_pkg.
`timescale 1ns / 1ps

module tpitf_checker #(
    parameter int ICON_DIM = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [tpitf_pkg::CMD_W-1:0]   i_cmd,
    input logic [tpitf_pkg::TEX_W-1:0]   i_tex_x,
    input logic [tpitf_pkg::TEX_W-1:0]   i_tex_y,
    input logic                          o_valid,
    input logic [15:0]                   o_texel_rgb5a1
);

    logic rd_acc;
    logic rd_out;

    assign rd_acc = start && !busy && (i_cmd == tpitf_pkg::CMD_READ);
    assign rd_out = ({2'b0, i_tex_x} >= 8'(ICON_DIM)) || ({2'b0, i_tex_y} >= 8'(ICON_DIM))
                 || ({2'b0, i_tex_x} >= 8'(tpitf_pkg::TEX_DIM))
                 || ({2'b0, i_tex_y} >= 8'(tpitf_pkg::TEX_DIM));

    // Every accepted read produces a result once it has passed the read pipeline.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |-> ##2 o_valid)
        else $error("texel read produced no result");

    // A result appears only for an accepted read, with no reset since its acceptance.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(rd_acc, 2) && $past(i_rst_n, 1) && $past(i_rst_n, 2)))
        else $error("result without a matching texel read");

    // A read outside the icon corner returns transparent zero.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_acc && rd_out) |-> ##2 (o_texel_rgb5a1 == 16'h0000))
        else $error("texel outside the icon is not zero");

    // Any nonzero color comes from a converted palette entry with alpha set.
    a_alpha_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_texel_rgb5a1 != 16'h0000)) |-> o_texel_rgb5a1[0])
        else $error("nonzero texel without alpha");

endmodule

bind tiled_palette_icon_texel_fetch tpitf_checker #(.ICON_DIM(ICON_DIM)) u_tpitf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .i_tex_x        (i_tex_x),
    .i_tex_y        (i_tex_y),
    .o_valid        (o_valid),
    .o_texel_rgb5a1 (o_texel_rgb5a1)
);
